// ===== rtl/readahead_ring_buffer_control_defines.svh =====
// ----------------------------------------------------------------------------
// Read-ahead ring buffer control - assertion macros
// Shared assertion helpers for the controller checks.
// ----------------------------------------------------------------------------
`ifndef READAHEAD_RING_BUFFER_CONTROL_DEFINES_SVH
`define READAHEAD_RING_BUFFER_CONTROL_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RRBC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrbc check failed");

// next-cycle implication, disabled in reset
`define RRBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrbc check failed");

`endif

// ===== rtl/rrbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Read-ahead ring buffer control - package
// Widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rrbc_pkg;

   localparam int OFS_W  = 64;
   localparam int AMT_W  = 21;
   localparam int POS_W  = 20;
   localparam int OP_W   = 3;
   localparam int ACT_W  = 3;
   localparam int THR_W  = 61;
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 64;

   localparam int DEF_RING_BITS = 20;

   // operation codes
   localparam logic [OP_W-1:0] OP_PLAN      = 3'd0;
   localparam logic [OP_W-1:0] OP_SEEK_DONE = 3'd1;
   localparam logic [OP_W-1:0] OP_READ_DONE = 3'd2;
   localparam logic [OP_W-1:0] OP_RSEEK     = 3'd3;
   localparam logic [OP_W-1:0] OP_RREAD     = 3'd4;
   localparam logic [OP_W-1:0] OP_PAUSE     = 3'd5;

   // action codes
   localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_PAUSE    = 3'd1;
   localparam logic [ACT_W-1:0] ACT_SEEK     = 3'd2;
   localparam logic [ACT_W-1:0] ACT_READ     = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DELIVER  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_NOTREADY = 3'd5;
   localparam logic [ACT_W-1:0] ACT_END      = 3'd6;
   localparam logic [ACT_W-1:0] ACT_FAILED   = 3'd7;

   // register indexes
   localparam logic [CSR_IW-1:0] CSR_RING_SIZE   = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_CHUNK_LIMIT = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_SKIP_THRESH = 2'd2;
   localparam logic [CSR_IW-1:0] CSR_SEEK_EN     = 2'd3;

   localparam logic [AMT_W-1:0] RST_RING_SIZE = 21'd1048576;
   localparam logic [AMT_W-1:0] RST_CHUNK     = 21'd16384;
   localparam logic [THR_W-1:0] RST_SKIP      = 61'd16384;

   // completion kinds after the modulo pass
   typedef enum logic [1:0] {
      FIN_READ,
      FIN_POS,
      FIN_DELIVER
   } fin_kind_type;

   typedef struct packed {
      logic load;
      logic decide;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic need_mod;
      logic mod_done;
   } status_type;

endpackage

// ===== rtl/rrbc_mod.sv =====
// ----------------------------------------------------------------------------
// Read-ahead ring buffer control - modulo unit
// Bit-serial restoring remainder of a 64-bit offset by the ring size.
// ----------------------------------------------------------------------------
module rrbc_mod (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rrbc_pkg::OFS_W-1:0] dividend,
   input  logic [rrbc_pkg::AMT_W-1:0] divisor,
   output logic                       done,
   output logic [rrbc_pkg::AMT_W-1:0] remainder
);
   import rrbc_pkg::*;

   localparam int CNT_W = $clog2(OFS_W + 1);

   logic [OFS_W-1:0] shift_ff, shift_in;
   logic [AMT_W-1:0] div_ff, div_in;
   logic [AMT_W:0]   rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [AMT_W:0]   trial;

   // one quotient bit per cycle
   always_comb begin
      shift_in = shift_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff[AMT_W-1:0], shift_ff[OFS_W-1]};
      if (start) begin
         shift_in = dividend;
         div_in   = divisor;
         rem_in   = '0;
         cnt_in   = CNT_W'(OFS_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[OFS_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[AMT_W-1:0];

endmodule

// ===== rtl/rrbc_dp.sv =====
// ----------------------------------------------------------------------------
// Read-ahead ring buffer control - datapath
// Window state, configuration, per-item decisions and result registers.
// ----------------------------------------------------------------------------
module rrbc_dp #(
   parameter int RING_BITS = rrbc_pkg::DEF_RING_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rrbc_pkg::cmd_type           cmd,
   output rrbc_pkg::status_type        status,
   input  logic [rrbc_pkg::OP_W-1:0]   req_operation,
   input  logic [rrbc_pkg::OFS_W-1:0]  req_offset,
   input  logic [rrbc_pkg::AMT_W-1:0]  req_amount,
   input  logic                        req_flag,
   input  logic                        csr_write,
   input  logic [rrbc_pkg::CSR_IW-1:0] csr_index,
   input  logic [rrbc_pkg::CSR_DW-1:0] csr_data,
   output logic [rrbc_pkg::ACT_W-1:0]  rsp_action,
   output logic [rrbc_pkg::POS_W-1:0]  rsp_position,
   output logic [rrbc_pkg::AMT_W-1:0]  rsp_length,
   output logic [rrbc_pkg::OFS_W-1:0]  rsp_target,
   output logic                        rsp_pause_value
);
   import rrbc_pkg::*;

   localparam logic [31:0] RING_CAP = 32'd1 << RING_BITS;

   // configuration
   logic [AMT_W-1:0] ring_size_ff, chunk_ff;
   logic [THR_W-1:0] skip_ff;
   logic             seek_en_ff;

   // window state
   logic [OFS_W-1:0] base_ff, base_in;
   logic [OFS_W-1:0] reader_ff, reader_in;
   logic [AMT_W-1:0] fill_ff, fill_in;
   logic end_ff, end_in, failed_ff, failed_in;
   logic pw_ff, pw_in, up_ff, up_in;

   // captured item
   logic [OP_W-1:0]  op_ff, op_in;
   logic [OFS_W-1:0] ofs_ff, ofs_in;
   logic [AMT_W-1:0] amt_ff, amt_in;
   logic             flag_ff, flag_in;

   // working and result registers
   logic [AMT_W-1:0] len_ff, len_in;
   fin_kind_type     fin_ff, fin_in;
   logic [ACT_W-1:0] act_ff, act_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [AMT_W-1:0] olen_ff, olen_in;
   logic [OFS_W-1:0] tgt_ff, tgt_in;
   logic             pv_ff, pv_in;

   logic [AMT_W-1:0] ring, chunk, room, take, copy, mod_res, clip;
   logic [OFS_W-1:0] history, mod_x;
   logic [AMT_W:0]   end_sum;
   logic             need_mod, at_end, mod_done;

   // effective ring size and chunk
   always_comb begin
      if ({11'b0, ring_size_ff} > RING_CAP) begin
         ring = RING_CAP[AMT_W-1:0];
      end else begin
         ring = ring_size_ff;
      end
      if (ring == '0) begin
         ring = AMT_W'(1);
      end
      chunk = (chunk_ff > ring) ? ring : chunk_ff;
      if (chunk == '0) begin
         chunk = AMT_W'(1);
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= RST_RING_SIZE;
         chunk_ff     <= RST_CHUNK;
         skip_ff      <= RST_SKIP;
         seek_en_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_RING_SIZE:   ring_size_ff <= csr_data[AMT_W-1:0];
            CSR_CHUNK_LIMIT: chunk_ff     <= csr_data[AMT_W-1:0];
            CSR_SKIP_THRESH: skip_ff      <= csr_data[THR_W-1:0];
            CSR_SEEK_EN:     seek_en_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // decide and finish steps
   always_comb begin
      base_in = base_ff;  reader_in = reader_ff; fill_in = fill_ff;
      end_in = end_ff;    failed_in = failed_ff;
      pw_in = pw_ff;      up_in = up_ff;
      op_in = op_ff;      ofs_in = ofs_ff;  amt_in = amt_ff;  flag_in = flag_ff;
      len_in = len_ff;    fin_in = fin_ff;
      act_in = act_ff;    pos_in = pos_ff;  olen_in = olen_ff;
      tgt_in = tgt_ff;    pv_in = pv_ff;
      need_mod = 1'b0;
      mod_x    = '0;
      history  = reader_ff - base_ff;
      room     = (fill_ff < ring) ? ring - fill_ff : '0;
      take     = '0;
      copy     = '0;
      at_end   = 1'b0;
      end_sum  = {1'b0, mod_res} + {1'b0, len_ff};
      clip     = (end_sum > {1'b0, ring}) ? ring - mod_res : len_ff;

      if (cmd.load) begin
         op_in   = req_operation;
         ofs_in  = req_offset;
         amt_in  = req_amount;
         flag_in = req_flag;
      end

      if (cmd.decide) begin
         act_in = ACT_NONE; pos_in = '0; olen_in = '0; tgt_in = '0; pv_in = 1'b0;
         case (op_ff)
            OP_PLAN: begin
               if (pw_ff != up_ff) begin
                  up_in  = pw_ff;
                  act_in = ACT_PAUSE;
                  pv_in  = pw_ff;
               end else if (up_ff || failed_ff) begin
                  act_in = ACT_NONE;
               end else if (reader_ff < base_ff) begin
                  act_in = ACT_SEEK;
                  tgt_in = reader_ff;
               end else if (end_ff) begin
                  act_in = ACT_NONE;
               end else if (seek_en_ff &&
                            history >= ({43'b0, fill_ff} + {3'b0, skip_ff})) begin
                  act_in = ACT_SEEK;
                  tgt_in = reader_ff;
               end else if (fill_ff >= ring) begin
                  if (history != '0) begin
                     // drop history, then read at the same ring edge
                     take = (history > {43'b0, chunk}) ? chunk : history[AMT_W-1:0];
                     if (take > fill_ff) begin
                        take = fill_ff;
                     end
                     base_in  = base_ff + {43'b0, take};
                     fill_in  = fill_ff - take;
                     len_in   = take;
                     fin_in   = FIN_READ;
                     need_mod = 1'b1;
                     mod_x    = base_ff + {43'b0, fill_ff};
                  end
               end else begin
                  len_in   = (ring - fill_ff > chunk) ? chunk : ring - fill_ff;
                  fin_in   = FIN_READ;
                  need_mod = 1'b1;
                  mod_x    = base_ff + {43'b0, fill_ff};
               end
            end
            OP_SEEK_DONE: begin
               if (flag_ff) begin
                  base_in = ofs_ff;
                  fill_in = '0;
                  end_in  = 1'b0;
               end else begin
                  failed_in = 1'b1;
               end
            end
            OP_READ_DONE: begin
               if (!flag_ff) begin
                  if (amt_ff == '0) begin
                     end_in = 1'b1;
                  end
                  fill_in = fill_ff + ((amt_ff > room) ? room : amt_ff);
               end
            end
            OP_RSEEK: begin
               reader_in = ofs_ff;
               failed_in = 1'b0;
               fin_in    = FIN_POS;
               need_mod  = 1'b1;
               mod_x     = ofs_ff;
            end
            OP_RREAD: begin
               if (amt_ff == '0) begin
                  len_in   = '0;
                  fin_in   = FIN_DELIVER;
                  need_mod = 1'b1;
                  mod_x    = reader_ff;
               end else begin
                  pw_in = 1'b0;
                  if (reader_ff >= base_ff) begin
                     if (history >= {43'b0, fill_ff}) begin
                        at_end = end_ff;
                     end else begin
                        copy = fill_ff - history[AMT_W-1:0];
                     end
                  end
                  if (copy == '0) begin
                     if (at_end) begin
                        act_in = ACT_END;
                     end else if (failed_ff) begin
                        act_in = ACT_FAILED;
                     end else begin
                        act_in = ACT_NOTREADY;
                     end
                  end else begin
                     len_in   = (copy > amt_ff) ? amt_ff : copy;
                     fin_in   = FIN_DELIVER;
                     need_mod = 1'b1;
                     mod_x    = reader_ff;
                  end
               end
            end
            OP_PAUSE: begin
               pw_in = flag_ff;
            end
            default: ;
         endcase
      end

      if (cmd.finish) begin
         pos_in = mod_res[POS_W-1:0];
         case (fin_ff)
            FIN_READ: begin
               act_in  = ACT_READ;
               olen_in = clip;
            end
            FIN_DELIVER: begin
               act_in    = ACT_DELIVER;
               olen_in   = clip;
               reader_in = reader_ff + {43'b0, clip};
            end
            default: begin
               act_in  = ACT_NONE;
               olen_in = '0;
            end
         endcase
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         reader_ff <= '0;
         fill_ff   <= '0;
         end_ff    <= 1'b0;
         failed_ff <= 1'b0;
         pw_ff     <= 1'b0;
         up_ff     <= 1'b0;
      end else begin
         base_ff   <= base_in;
         reader_ff <= reader_in;
         fill_ff   <= fill_in;
         end_ff    <= end_in;
         failed_ff <= failed_in;
         pw_ff     <= pw_in;
         up_ff     <= up_in;
      end
      op_ff   <= op_in;
      ofs_ff  <= ofs_in;
      amt_ff  <= amt_in;
      flag_ff <= flag_in;
      len_ff  <= len_in;
      fin_ff  <= fin_in;
      act_ff  <= act_in;
      pos_ff  <= pos_in;
      olen_ff <= olen_in;
      tgt_ff  <= tgt_in;
      pv_ff   <= pv_in;
   end

   // ring index of an offset
   rrbc_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.decide && need_mod),
      .dividend  (mod_x),
      .divisor   (ring),
      .done      (mod_done),
      .remainder (mod_res)
   );

   assign status.need_mod = need_mod;
   assign status.mod_done = mod_done;
   assign rsp_action      = act_ff;
   assign rsp_position    = pos_ff;
   assign rsp_length      = olen_ff;
   assign rsp_target      = tgt_ff;
   assign rsp_pause_value = pv_ff;

endmodule

// ===== rtl/rrbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Read-ahead ring buffer control - controller
// Sequences one item: capture, decide, modulo wait, result hand-off.
// ----------------------------------------------------------------------------
`include "readahead_ring_buffer_control_defines.svh"

module rrbc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rrbc_pkg::cmd_type    cmd,
   input  rrbc_pkg::status_type status
);
   import rrbc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MOD,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      req_xfer, rsp_xfer;

   assign req_xfer   = req_valid && req_ready_ff;
   assign rsp_xfer   = rsp_valid_ff && rsp_ready;
   assign cmd.load   = req_xfer;
   assign cmd.decide = (state_ff == ST_DECIDE);
   assign cmd.finish = (state_ff == ST_MOD) && status.mod_done;

   // state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  state_ff     <= ST_DECIDE;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_DECIDE: begin
               if (status.need_mod) begin
                  state_ff <= ST_MOD;
               end else begin
                  state_ff     <= ST_RESP;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_MOD: begin
               if (status.mod_done) begin
                  state_ff     <= ST_RESP;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_RESP: begin
               if (rsp_xfer) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   // checks
   `RRBC_ASSERT_IMPL(a_one_side, clock, reset, req_ready_ff, !rsp_valid_ff)
   `RRBC_ASSERT_NEXT(a_take_decide, clock, reset, req_xfer, state_ff == ST_DECIDE)
   `RRBC_ASSERT_NEXT(a_rsp_reopen, clock, reset, rsp_xfer, req_ready_ff)
   `RRBC_ASSERT_IMPL(a_done_in_mod, clock, reset, status.mod_done, state_ff == ST_MOD)

endmodule

// ===== rtl/readahead_ring_buffer_control.sv =====
// ----------------------------------------------------------------------------
// Read-ahead ring buffer control - top level
// Planning and bookkeeping for a read-ahead ring between source and reader.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item (plan, seek_done, read_done, reader seek, reader
//   read, pause); rsp_* returns exactly one result per item. csr_* writes the
//   ring size, chunk limit, skip threshold and seek enable; write only while
//   no item is in flight. csr_ready is always high.
//   One item is worked on at a time. Items that need a ring index (plan read,
//   reader seek, reader read) wait between transfer and rsp_valid for the
//   bit-serial 64-bit modulo unit (one bit per cycle); all other items go
//   from the decide step straight to the result. req_ready returns the
//   cycle after the result transfer, so no new item is taken before it.
//   Reset clears the window state and loads the register defaults.
//   While rsp_ready is low the result holds in its output register and no
//   new item is taken.
// ----------------------------------------------------------------------------
module readahead_ring_buffer_control #(
   parameter int RING_BITS = rrbc_pkg::DEF_RING_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [rrbc_pkg::OP_W-1:0]   req_operation,
   input  logic [rrbc_pkg::OFS_W-1:0]  req_offset,
   input  logic [rrbc_pkg::AMT_W-1:0]  req_amount,
   input  logic                        req_flag,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rrbc_pkg::ACT_W-1:0]  rsp_action,
   output logic [rrbc_pkg::POS_W-1:0]  rsp_position,
   output logic [rrbc_pkg::AMT_W-1:0]  rsp_length,
   output logic [rrbc_pkg::OFS_W-1:0]  rsp_target,
   output logic                        rsp_pause_value,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rrbc_pkg::CSR_IW-1:0] csr_index,
   input  logic [rrbc_pkg::CSR_DW-1:0] csr_data
);
   import rrbc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // sequencing
   rrbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // state, registers and results
   rrbc_dp #(
      .RING_BITS (RING_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_operation),
      .req_offset      (req_offset),
      .req_amount      (req_amount),
      .req_flag        (req_flag),
      .csr_write       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_action      (rsp_action),
      .rsp_position    (rsp_position),
      .rsp_length      (rsp_length),
      .rsp_target      (rsp_target),
      .rsp_pause_value (rsp_pause_value)
   );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Read-ahead ring buffer control - testbench
// Drives plan, upstream completion, reader and pause items with random gaps,
// predicts every result from a shadow of the window state and the registers,
// and compares each result transfer field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
   import rrbc_pkg::*;

   localparam int RING_CAP    = 1 << DEF_RING_BITS;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [OFS_W-1:0] offset;
      logic [AMT_W-1:0] amount;
      logic             flag;
   } item_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [POS_W-1:0] position;
      logic [AMT_W-1:0] length;
      logic [OFS_W-1:0] target;
      logic             pause_value;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   logic [OP_W-1:0] req_operation = '0;
   logic [OFS_W-1:0] req_offset = '0;
   logic [AMT_W-1:0] req_amount = '0;
   logic req_flag = 1'b0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic [ACT_W-1:0] rsp_action;
   logic [POS_W-1:0] rsp_position;
   logic [AMT_W-1:0] rsp_length;
   logic [OFS_W-1:0] rsp_target;
   logic rsp_pause_value;
   logic csr_valid = 1'b0, csr_ready;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_data = '0;

   readahead_ring_buffer_control dut (.*);

   always #5 clock = ~clock;

   // shadow registers and window state
   logic [AMT_W-1:0] sh_ring_size, sh_chunk;
   logic [THR_W-1:0] sh_skip;
   logic sh_seek_en;
   logic [63:0] win_base, win_reader, win_fill;
   logic win_end, win_failed, want_pause, up_paused;

   item_type   pending_items[$];
   result_type expected_results[$];
   int issued = 0, accepted = 0, csr_writes = 0, fails = 0, cycles = 0;

   function automatic result_type mk(logic [ACT_W-1:0] a, logic [63:0] p, logic [63:0] l,
                                     logic [63:0] t, logic v);
      result_type r;
      r.action = a; r.position = p[POS_W-1:0]; r.length = l[AMT_W-1:0];
      r.target = t; r.pause_value = v;
      return r;
   endfunction

   function automatic logic [63:0] ring_eff();
      logic [63:0] r;
      r = sh_ring_size;
      if (r > RING_CAP) r = RING_CAP;
      if (r == 0) r = 1;
      return r;
   endfunction

   // next upstream action for a plan item
   function automatic result_type plan_action();
      logic [63:0] ring, chunk, hist, len, pos;
      ring = ring_eff();
      chunk = sh_chunk;
      if (chunk > ring) chunk = ring;
      if (chunk == 0) chunk = 1;
      if (want_pause != up_paused) begin
         up_paused = want_pause;
         return mk(ACT_PAUSE, 0, 0, 0, up_paused);
      end
      if (up_paused || win_failed) return mk(ACT_NONE, 0, 0, 0, 0);
      if (win_reader < win_base) return mk(ACT_SEEK, 0, 0, win_reader, 0);
      if (win_end) return mk(ACT_NONE, 0, 0, 0, 0);
      hist = win_reader - win_base;
      if (sh_seek_en && hist >= win_fill + {3'b0, sh_skip})
         return mk(ACT_SEEK, 0, 0, win_reader, 0);
      if (win_fill >= ring) begin
         if (hist == 0) return mk(ACT_NONE, 0, 0, 0, 0);
         len = hist;
         if (len > chunk) len = chunk;
         if (len > win_fill) len = win_fill;
         win_base += len;
         win_fill -= len;
      end else begin
         len = ring - win_fill;
         if (len > chunk) len = chunk;
      end
      pos = (win_base + win_fill) % ring;
      if (pos + len > ring) len = ring - pos;
      return mk(ACT_READ, pos, len, 0, 0);
   endfunction

   // copy answer for a reader read item
   function automatic result_type reader_copy(logic [63:0] amount);
      logic [63:0] ring, copy, pos;
      logic at_end;
      ring = ring_eff();
      copy = 0;
      at_end = 1'b0;
      if (amount == 0) return mk(ACT_DELIVER, win_reader % ring, 0, 0, 0);
      want_pause = 1'b0;
      if (win_reader >= win_base) begin
         if (win_reader - win_base >= win_fill) at_end = win_end;
         else copy = win_fill - (win_reader - win_base);
      end
      if (copy == 0) begin
         if (at_end) return mk(ACT_END, 0, 0, 0, 0);
         if (win_failed) return mk(ACT_FAILED, 0, 0, 0, 0);
         return mk(ACT_NOTREADY, 0, 0, 0, 0);
      end
      pos = win_reader % ring;
      if (copy > amount) copy = amount;
      if (pos + copy > ring) copy = ring - pos;
      win_reader += copy;
      return mk(ACT_DELIVER, pos, copy, 0, 0);
   endfunction

   function automatic result_type window_step(item_type it);
      logic [63:0] ring, room, amt;
      case (it.op)
         OP_PLAN: return plan_action();
         OP_SEEK_DONE: begin
            if (it.flag) begin
               win_base = it.offset; win_fill = 0; win_end = 1'b0;
            end else win_failed = 1'b1;
         end
         OP_READ_DONE: begin
            if (!it.flag) begin
               ring = ring_eff();
               room = (win_fill < ring) ? ring - win_fill : 0;
               amt = it.amount;
               if (amt == 0) win_end = 1'b1;
               if (amt > room) amt = room;
               win_fill += amt;
            end
         end
         OP_RSEEK: begin
            win_reader = it.offset;
            win_failed = 1'b0;
            return mk(ACT_NONE, win_reader % ring_eff(), 0, 0, 0);
         end
         OP_RREAD: return reader_copy(it.amount);
         OP_PAUSE: want_pause = it.flag;
         default: ;
      endcase
      return mk(ACT_NONE, 0, 0, 0, 0);
   endfunction

   // accepted transfers feed the predictor; register writes update the shadow
   always @(posedge clock) begin
      cycles++;
      if (reset) begin
         sh_ring_size = RST_RING_SIZE; sh_chunk = RST_CHUNK; sh_skip = RST_SKIP;
         sh_seek_en = 1'b0;
         win_base = 0; win_reader = 0; win_fill = 0;
         win_end = 0; win_failed = 0; want_pause = 0; up_paused = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(window_step({req_operation, req_offset,
                                                    req_amount, req_flag}));
            accepted++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RING_SIZE:   sh_ring_size = csr_data[AMT_W-1:0];
               CSR_CHUNK_LIMIT: sh_chunk = csr_data[AMT_W-1:0];
               CSR_SKIP_THRESH: sh_skip = csr_data[THR_W-1:0];
               CSR_SEEK_EN:     sh_seek_en = csr_data[0];
               default: ;
            endcase
            csr_writes++;
         end
      end
   end

   // result check
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected");
            fails++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_action !== want.action) begin
               $error("action exp %0d got %0d", want.action, rsp_action); fails++;
            end
            if (rsp_position !== want.position) begin
               $error("position exp %0d got %0d", want.position, rsp_position); fails++;
            end
            if (rsp_length !== want.length) begin
               $error("length exp %0d got %0d", want.length, rsp_length); fails++;
            end
            if (rsp_target !== want.target) begin
               $error("target exp %0h got %0h", want.target, rsp_target); fails++;
            end
            if (rsp_pause_value !== want.pause_value) begin
               $error("pause_value exp %0d got %0d", want.pause_value, rsp_pause_value);
               fails++;
            end
         end
      end
   end

   // request driver: bursts and gaps
   int burst_left = 0, gap_left = 0;
   always @(negedge clock) begin
      item_type it;
      if (!reset && issued == accepted) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            req_operation <= it.op; req_offset <= it.offset;
            req_amount <= it.amount; req_flag <= it.flag;
            req_valid <= 1'b1;
            issued++;
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
            end
         end else req_valid <= 1'b0;
      end
   end

   // result receiver: own stall pattern plus one long hold-off
   int stall_mode = 0, mode_left = 0, hold_off = 0, long_done = 0;
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off--;
         rsp_ready <= 1'b0;
      end else if (!long_done && accepted > 300) begin
         long_done = 1;
         hold_off = 600;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 400);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic add(logic [OP_W-1:0] op, logic [63:0] ofs, logic [AMT_W-1:0] amt,
                      logic flg);
      pending_items.push_back({op, ofs, amt, flg});
   endtask

   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [63:0] value);
      int seen;
      seen = csr_writes;
      @(negedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= value;
      while (csr_writes == seen) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      wait (pending_items.size() == 0 && issued == accepted && expected_results.size() == 0);
      repeat (80) @(negedge clock);
   endtask

   // random items, mostly a plausible read-ahead flow around the window
   task automatic add_random(int n, int span);
      logic [63:0] ofs;
      int r;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 19) == 0) ofs = {$urandom, $urandom};
         else ofs = 64'($urandom_range(0, 4 * span));
         if (r < 30) add(OP_PLAN, {$urandom, $urandom}, AMT_W'($urandom), 1'($urandom));
         else if (r < 52)
            add(OP_READ_DONE, ofs, ($urandom_range(0, 19) == 0) ? 21'd0 :
                ($urandom_range(0, 9) == 0 ? AMT_W'($urandom) :
                 AMT_W'($urandom_range(1, span))), $urandom_range(0, 15) == 0);
         else if (r < 60)
            add(OP_SEEK_DONE, ofs, AMT_W'($urandom), $urandom_range(0, 5) != 0);
         else if (r < 70) add(OP_RSEEK, ofs, AMT_W'($urandom), 1'($urandom));
         else if (r < 92)
            add(OP_RREAD, ofs, ($urandom_range(0, 9) == 0) ? AMT_W'($urandom) :
                AMT_W'($urandom_range(0, span)), 1'($urandom));
         else if (r < 97) add(OP_PAUSE, ofs, AMT_W'($urandom), 1'($urandom));
         else add(OP_PLAN + 3'($urandom_range(6, 7)), ofs, AMT_W'($urandom),
                  1'($urandom));
      end
   endtask

   typedef struct packed {
      logic [63:0] ring, chunk, skip;
      logic seek;
      int span;
   } phase_type;

   initial begin
      phase_type phases[8];
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: default registers
      add(OP_PLAN, 0, 0, 0);
      add(OP_READ_DONE, 0, 21'd16384, 0);
      add(OP_RREAD, 0, 0, 0);
      add(OP_RREAD, 0, 21'd100, 0);
      add(OP_PLAN, 0, 0, 0);
      add(OP_RSEEK, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
      add(OP_PLAN, 0, 0, 0);
      add(OP_SEEK_DONE, 64'd5, 0, 0);
      add(OP_PLAN, 0, 0, 0);
      add(OP_RREAD, 0, 21'd10, 0);
      add(OP_RSEEK, 0, 0, 1);
      add(OP_PAUSE, 0, 0, 1);
      add(OP_PLAN, 0, 0, 0);
      add(OP_PLAN, 0, 0, 0);
      add(OP_RREAD, 0, 21'h1FFFFF, 0);
      add(OP_PLAN, 0, 0, 0);
      add(OP_READ_DONE, 0, 21'd77, 1);
      add(OP_READ_DONE, 0, 21'd0, 0);
      add(OP_RREAD, 0, 21'd1 << 20, 0);
      add(OP_RREAD, 0, 21'd1, 0);
      add(OP_PLAN, 0, 0, 0);
      add(3'd6, '1, '1, 1);
      add(3'd7, 0, 0, 0);
      add(OP_SEEK_DONE, 0, 0, 1);
      add(OP_READ_DONE, 0, 21'h1FFFFF, 0);
      wait_idle();

      // register settings, extremes included
      phases[0] = '{64'd64, 64'd16, 64'd8, 1'b1, 64};
      phases[1] = '{64'd0, 64'd0, 64'd0, 1'b1, 4};
      phases[2] = '{64'h1FFFFF, 64'h1FFFFF, 64'h1FFF_FFFF_FFFF_FFFF, 1'b0, 4096};
      phases[3] = '{64'd100, 64'd33, 64'd0, 1'b1, 100};
      phases[4] = '{64'd7, 64'd1, 64'd3, 1'b0, 7};
      phases[5] = '{64'd1 << 20, 64'd1 << 20, 64'd1 << 60, 1'b1, 1 << 20};
      phases[6] = '{64'd256, 64'd300, 64'd64, 1'b1, 256};
      phases[7] = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFE0_0010, '1, 1'b1, 32};
      foreach (phases[p]) begin
         write_reg(CSR_RING_SIZE, phases[p].ring);
         write_reg(CSR_CHUNK_LIMIT, phases[p].chunk);
         write_reg(CSR_SKIP_THRESH, phases[p].skip);
         write_reg(CSR_SEEK_EN, {63'd0, phases[p].seek});
         add(OP_RSEEK, 0, 0, 0);
         add(OP_SEEK_DONE, 0, 0, 1);
         add_random(96, phases[p].span);
         wait_idle();
      end

      if (fails == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
